// ----- rtl/bde_pkg.sv -----
// Shared types and constants for the button debounce and event detector.
// Used by bde_step and button_debounce_event_detector_core; no dependencies.
package bde_pkg;

  localparam int TIME_BITS   = 24;
  localparam int WINDOW_BITS = 16;
  localparam int COUNT_BITS  = 8;

  localparam int DEB_W   = 16;
  localparam int REP_W   = 24;
  localparam int CFG_W   = 24;
  localparam int EVENT_W = 3;
  localparam int CLICK_W = 8;
  localparam int HOLD_W  = 24;

  localparam logic [63:0] WIN_MAX = (64'd1 << WINDOW_BITS) - 64'd1;

  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(50);
  localparam logic [REP_W-1:0] REP_RESET = REP_W'(500);

  typedef enum logic [1:0] {
    REG_SWITCH_MODE    = 2'd0,
    REG_IDLE_HIGH      = 2'd1,
    REG_DEBOUNCE_TICKS = 2'd2,
    REG_REPEAT_TICKS   = 2'd3
  } reg_idx_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_CHANGED  = 3'd1,
    EV_PRESSED  = 3'd2,
    EV_RELEASED = 3'd3,
    EV_FINISHED = 3'd4
  } event_t;

  typedef struct packed {
    logic             switch_mode;
    logic             idle_high;
    logic [DEB_W-1:0] debounce_ticks;
    logic [REP_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   stable_level;
    logic                   primed;
    logic                   in_window;
    logic                   target_level;
    logic [WINDOW_BITS-1:0] window_count;
    logic [WINDOW_BITS-1:0] ones_seen;
    logic [WINDOW_BITS-1:0] zeros_seen;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   settled_ready;
    logic                   restart_count;
    logic [COUNT_BITS-1:0]  burst_count;
    logic [TIME_BITS-1:0]   last_hold;
  } state_t;

  typedef struct packed {
    event_t             event_code;
    logic [CLICK_W-1:0] click_total;
    logic [HOLD_W-1:0]  hold_length;
  } result_t;

  localparam state_t STATE_RESET = '{
    stable_level:  1'b0,
    primed:        1'b0,
    in_window:     1'b0,
    target_level:  1'b0,
    window_count:  '0,
    ones_seen:     '0,
    zeros_seen:    '0,
    elapsed:       '0,
    settled_ready: 1'b0,
    restart_count: 1'b1,
    burst_count:   '0,
    last_hold:     '0
  };

endpackage

// ----- rtl/bde_step.sv -----
// Next-state and result logic for one pin sample of the debouncer.
// Depends on bde_pkg for the state, configuration and result types.
module bde_step import bde_pkg::*; (
  input  cfg_t    cfg,
  input  state_t  st,
  input  logic    pin,
  output state_t  st_nxt,
  output result_t res
);

  logic [WINDOW_BITS-1:0] limit;
  logic                   ok;
  logic                   quiet;
  event_t                 ev;

  always_comb begin
    if (64'(cfg.debounce_ticks) < WIN_MAX) begin
      limit = WINDOW_BITS'(cfg.debounce_ticks);
    end else begin
      limit = WIN_MAX[WINDOW_BITS-1:0];
    end
  end

  always_comb begin
    st_nxt = st;
    ev     = EV_NONE;
    ok     = 1'b0;
    quiet  = 1'b0;

    if (!(&st.elapsed)) begin
      st_nxt.elapsed = st.elapsed + TIME_BITS'(1);
    end

    if (!st.primed) begin
      st_nxt.stable_level = cfg.switch_mode ? pin : cfg.idle_high;
      st_nxt.primed       = 1'b1;
    end else begin
      if (st.in_window) begin
        if (st.window_count < limit) begin
          if (pin) begin
            st_nxt.ones_seen = st.ones_seen + WINDOW_BITS'(1);
          end else begin
            st_nxt.zeros_seen = st.zeros_seen + WINDOW_BITS'(1);
          end
          st_nxt.window_count = st.window_count + WINDOW_BITS'(1);
        end else begin
          ok = st.target_level ? ((st.ones_seen > st.zeros_seen) && pin)
                               : ((st.zeros_seen > st.ones_seen) && !pin);
          st_nxt.in_window = 1'b0;
          if (ok) begin
            st_nxt.stable_level = st.target_level;
            if (cfg.switch_mode || (st.target_level != cfg.idle_high)) begin
              if (st.restart_count) begin
                st_nxt.burst_count   = COUNT_BITS'(1);
                st_nxt.restart_count = 1'b0;
              end else if (!(&st.burst_count)) begin
                st_nxt.burst_count = st.burst_count + COUNT_BITS'(1);
              end
            end
            if (cfg.switch_mode) begin
              ev                   = EV_CHANGED;
              st_nxt.elapsed       = '0;
              st_nxt.settled_ready = 1'b1;
            end else if (st.target_level == cfg.idle_high) begin
              st_nxt.last_hold     = st_nxt.elapsed;
              st_nxt.settled_ready = 1'b1;
            end else begin
              ev                   = EV_PRESSED;
              st_nxt.elapsed       = '0;
              st_nxt.last_hold     = '0;
              st_nxt.settled_ready = 1'b0;
            end
          end
        end
      end else if (pin != st.stable_level) begin
        st_nxt.in_window    = 1'b1;
        st_nxt.target_level = pin;
        st_nxt.window_count = '0;
        st_nxt.ones_seen    = '0;
        st_nxt.zeros_seen   = '0;
      end

      quiet = !st_nxt.in_window && st_nxt.settled_ready &&
              (64'(st_nxt.elapsed) > 64'(cfg.repeat_ticks));
      if (quiet) begin
        st_nxt.settled_ready = 1'b0;
        st_nxt.restart_count = 1'b1;
        ev = cfg.switch_mode ? EV_FINISHED : EV_RELEASED;
      end
    end

    res.event_code  = ev;
    res.click_total = CLICK_W'(st_nxt.burst_count);
    res.hold_length = HOLD_W'(st_nxt.last_hold);
  end

endmodule

// ----- rtl/button_debounce_event_detector_core.sv -----
// Button debounce and event detector, top level: input register, step logic, result register.
// Path: an accepted sample goes into the input register, then via bde_step into res_r.
// Throughput: one sample per cycle unless out_stall holds; one bde_step pass per update.
// Reset: synchronous, active low; clears state, valid flags and loads register defaults.
// Depends on bde_pkg and bde_step.
module button_debounce_event_detector_core import bde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_pin_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [EVENT_W-1:0] out_event_code,
  output logic [CLICK_W-1:0] out_click_total,
  output logic [HOLD_W-1:0]  out_hold_length
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    in_vld_r;
  logic    in_pin_r;
  logic    out_vld_r;
  logic    out_free;
  logic    advance;

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.switch_mode    <= 1'b0;
      cfg_r.idle_high      <= 1'b0;
      cfg_r.debounce_ticks <= DEB_RESET;
      cfg_r.repeat_ticks   <= REP_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SWITCH_MODE:    cfg_r.switch_mode    <= cfg_wdata[0];
        REG_IDLE_HIGH:      cfg_r.idle_high      <= cfg_wdata[0];
        REG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_wdata[DEB_W-1:0];
        REG_REPEAT_TICKS:   cfg_r.repeat_ticks   <= cfg_wdata[REP_W-1:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_pin_r <= in_pin_level;
    end
  end

  bde_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .pin    (in_pin_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_event_code  = res_r.event_code;
  assign out_click_total = res_r.click_total;
  assign out_hold_length = res_r.hold_length;

`ifndef SYNTHESIS
  a_window_needs_prime: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.in_window |-> state_r.primed)
    else $error("debounce window open before first sample");

  a_press_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.event_code == EV_PRESSED) |=> (state_r.elapsed == '0))
    else $error("press did not clear elapsed time");

  a_click_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((res_r.event_code == EV_CHANGED) || (res_r.event_code == EV_PRESSED))
    |-> (res_r.click_total != '0))
    else $error("click event with zero click total");
`endif

endmodule

// ----- dv/tb_button_debounce_event_detector_core.sv -----
// Testbench for button_debounce_event_detector_core: random valid/stall traffic on both
// channels, a cycle-free event predictor and an in-order result check.
// Depends on rtl/bde_pkg.sv and the core RTL.
module tb_button_debounce_event_detector_core import bde_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  class click_event_checker;
    cfg_t    cfg;
    state_t  st;
    result_t expected_events[$];
    int      errors;
    int      samples;
    int      event_tally[8];

    function new();
      cfg = '{switch_mode: 1'b0, idle_high: 1'b0,
              debounce_ticks: DEB_RESET, repeat_ticks: REP_RESET};
      st = STATE_RESET;
      errors = 0;
      samples = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SWITCH_MODE:    cfg.switch_mode = val[0];
        REG_IDLE_HIGH:      cfg.idle_high = val[0];
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks = val[DEB_W-1:0];
        REG_REPEAT_TICKS:   cfg.repeat_ticks = val[REP_W-1:0];
        default: ;
      endcase
    endfunction

    function void count_click();
      if (st.restart_count) begin
        st.burst_count = COUNT_BITS'(1);
        st.restart_count = 1'b0;
      end else if (st.burst_count != '1) begin
        st.burst_count = st.burst_count + 1'b1;
      end
    endfunction

    function result_t predict_event(logic pin);
      event_t ev;
      logic   accept;
      ev = EV_NONE;
      if (st.elapsed != '1) st.elapsed = st.elapsed + 1'b1;
      if (!st.primed) begin
        st.stable_level = cfg.switch_mode ? pin : cfg.idle_high;
        st.primed = 1'b1;
      end else begin
        if (st.in_window) begin
          if (st.window_count < cfg.debounce_ticks) begin
            if (pin) st.ones_seen = st.ones_seen + 1'b1;
            else st.zeros_seen = st.zeros_seen + 1'b1;
            st.window_count = st.window_count + 1'b1;
          end else begin
            accept = st.target_level ? (st.ones_seen > st.zeros_seen && pin)
                                     : (st.zeros_seen > st.ones_seen && !pin);
            st.in_window = 1'b0;
            if (accept) begin
              st.stable_level = st.target_level;
              if (cfg.switch_mode) begin
                ev = EV_CHANGED;
                st.elapsed = '0;
                st.settled_ready = 1'b1;
                count_click();
              end else if (st.stable_level == cfg.idle_high) begin
                st.last_hold = st.elapsed;
                st.settled_ready = 1'b1;
              end else begin
                ev = EV_PRESSED;
                st.elapsed = '0;
                st.last_hold = '0;
                count_click();
                st.settled_ready = 1'b0;
              end
            end
          end
        end else if (pin != st.stable_level) begin
          st.in_window = 1'b1;
          st.target_level = pin;
          st.window_count = '0;
          st.ones_seen = '0;
          st.zeros_seen = '0;
        end
        if (!st.in_window && st.settled_ready && st.elapsed > TIME_BITS'(cfg.repeat_ticks)) begin
          st.settled_ready = 1'b0;
          st.restart_count = 1'b1;
          ev = cfg.switch_mode ? EV_FINISHED : EV_RELEASED;
        end
      end
      return '{event_code: ev, click_total: st.burst_count, hold_length: st.last_hold};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function void note_sample(logic pin);
      samples++;
      expected_events.push_back(predict_event(pin));
    endfunction

    task check_event(logic [EVENT_W-1:0] code, logic [CLICK_W-1:0] clicks,
                     logic [HOLD_W-1:0] hold);
      result_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("result with nothing pending (event %0d)", code));
        return;
      end
      want = expected_events.pop_front();
      if (code !== want.event_code)
        report($sformatf("event_code got %0d want %0d", code, want.event_code));
      if (clicks !== want.click_total)
        report($sformatf("click_total got %0d want %0d", clicks, want.click_total));
      if (hold !== want.hold_length)
        report($sformatf("hold_length got %0d want %0d", hold, want.hold_length));
      event_tally[want.event_code]++;
    endtask

    task report_leftovers();
      if (expected_events.size() != 0)
        report($sformatf("%0d results never arrived", expected_events.size()));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  reg_idx_t            cfg_index = REG_SWITCH_MODE;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_pin_level = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [EVENT_W-1:0]  out_event_code;
  logic [CLICK_W-1:0]  out_click_total;
  logic [HOLD_W-1:0]   out_hold_length;

  click_event_checker  tracker;
  logic                calm = 1'b0;
  int                  stall_run = 0;
  int                  deb_cur = 50;
  int                  rep_cur = 500;
  int                  settings = 0;

  button_debounce_event_detector_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_click_total (out_click_total),
    .out_hold_length (out_hold_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else if (calm || !rst_n) begin
      out_stall = 1'b0;
    end else if (out_stall) begin
      out_stall = 1'b0;
      stall_run = $urandom_range(0, 5);
    end else begin
      out_stall = 1'b1;
      stall_run = ($urandom_range(99) < 85) ? $urandom_range(0, 2) : $urandom_range(8, 40);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_sample(in_pin_level);
      if (out_valid && !out_stall)
        tracker.check_event(out_event_code, out_click_total, out_hold_length);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(input logic lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pin_level = lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_bits(input logic [31:0] bits, input int n);
    for (int k = n - 1; k >= 0; k--) send_sample(bits[k]);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (tracker.expected_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic sw, input logic idle, input logic [DEB_W-1:0] deb,
                           input logic [REP_W-1:0] rep);
    settle();
    write_reg(REG_SWITCH_MODE, CFG_W'(sw));
    write_reg(REG_IDLE_HIGH, CFG_W'(idle));
    write_reg(REG_DEBOUNCE_TICKS, CFG_W'(deb));
    write_reg(REG_REPEAT_TICKS, CFG_W'(rep));
    deb_cur = deb;
    rep_cur = rep;
    settings++;
  endtask

  // Alternate levels in runs sized to pass the window (at most 120 samples), mixed with quiet
  // holds meant to close a burst and short glitches of one to three samples meant to be rejected.
  task automatic drive_bursts(input int n_items, input int noise_pct, input int quiet_pct,
                              input int short_pct);
    int   sent;
    int   len;
    int   kind;
    logic lvl;
    sent = 0;
    lvl = 1'($urandom_range(1));
    while (sent < n_items) begin
      kind = $urandom_range(99);
      lvl = ~lvl;
      calm = ($urandom_range(9) == 0);
      if (kind < quiet_pct)
        len = ((rep_cur < 60) ? rep_cur : 60) + ((deb_cur < 60) ? deb_cur : 60) + 3;
      else if (kind < quiet_pct + short_pct)
        len = $urandom_range(1, 3);
      else
        len = deb_cur + 2 + (($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
      if (len > 120) len = 120;
      if (len > n_items - sent) len = n_items - sent;
      for (int k = 0; k < len; k++)
        send_sample(($urandom_range(99) < noise_pct) ? ~lvl : lvl);
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    tracker = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    configure(1'b1, 1'b1, 16'd1, 24'd2);
    send_bits(32'b1000000111010, 13);
    configure(1'b0, 1'b0, 16'd1, 24'd1);
    send_bits(32'b00000111000000, 14);

    configure(1'b0, 1'b0, DEB_W'($urandom_range(1, 4)), REP_W'($urandom_range(3, 30)));
    drive_bursts(120, 5, 15, 15);
    configure(1'b0, 1'b1, DEB_W'($urandom_range(2, 6)), 24'd0);
    drive_bursts(120, 8, 10, 20);
    configure(1'b1, 1'b0, DEB_W'($urandom_range(1, 3)), REP_W'($urandom_range(5, 40)));
    drive_bursts(120, 5, 15, 15);
    configure(1'b1, 1'b1, 16'd0, 24'd10);
    drive_bursts(40, 10, 10, 10);
    configure(1'b0, 1'b1, 16'hFFFF, 24'hFFFFFF);
    drive_bursts(60, 10, 10, 10);
    configure(1'b1, 1'b0, 16'd1, 24'hFFFFFF);
    drive_bursts(880, 0, 0, 0);
    configure(1'b0, 1'b1, DEB_W'($urandom_range(1, 5)), REP_W'($urandom_range(0, 20)));
    drive_bursts(100, 8, 15, 15);

    in_valid = 1'b0;
    waited = 0;
    while (tracker.expected_events.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    tracker.report_leftovers();

    $display("Run covered %0d samples under %0d register settings.", tracker.samples, settings);
    $display("Events seen: none %0d, changed %0d, pressed %0d, released %0d, finished %0d",
             tracker.event_tally[EV_NONE], tracker.event_tally[EV_CHANGED],
             tracker.event_tally[EV_PRESSED], tracker.event_tally[EV_RELEASED],
             tracker.event_tally[EV_FINISHED]);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout waiting for the block");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bde_pkg.sv
rtl/bde_step.sv
rtl/button_debounce_event_detector_core.sv
dv/tb_button_debounce_event_detector_core.sv
